// ===== src/xorshift128_prng_with_seed_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the xorshift128 generator.
// Build with NO_ASSERTIONS defined to drop every check.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT128_PRNG_WITH_SEED_DEFINES_SVH
`define XORSHIFT128_PRNG_WITH_SEED_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, suspended while reset is asserted.
`define XS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define XS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XS_ASSERT_CLK(lbl, prop, msg)
`define XS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/xs128_pkg.sv =====
// ----------------------------------------------------------------------------
// xs128_pkg
// Command codes and constants of the xorshift128 generator.
// ----------------------------------------------------------------------------
package xs128_pkg;

	localparam int CMD_W  = 2;
	localparam int WORD_W = 32;
	localparam int OUT_W  = 31;

	localparam logic [CMD_W-1:0] CMD_SEED   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DRAW15 = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FRAC31 = 2'd2;

	localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_OFFSET = 32'd100;

	// One xorshift128 step: returns the new last word from the first and last words.
	function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] w0,
	                                              input logic [WORD_W-1:0] w3);
		logic [WORD_W-1:0] t;
		t = w0 ^ (w0 << 11);
		return (w3 ^ (w3 >> 19)) ^ (t ^ (t >> 8));
	endfunction

endpackage

// ===== src/xorshift128_prng_with_seed.sv =====
// ----------------------------------------------------------------------------
// xorshift128_prng_with_seed
// Draws: ST_WORK registers the result; one per cycle unless out_stall holds.
// Seed: four multiply/add rounds through one shared multiplier.
// Reset clears the state words to zero, so draws before a seed return zero.
// ----------------------------------------------------------------------------
`include "xorshift128_prng_with_seed_defines.svh"

module xorshift128_prng_with_seed (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [xs128_pkg::CMD_W-1:0]   cmd,
	input  logic [xs128_pkg::WORD_W-1:0]  seed_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [xs128_pkg::OUT_W-1:0]   random_value
);
	import xs128_pkg::*;

	// ST_IDLE holds no transaction. ST_WORK holds a draw (or the unused code)
	// that completes as soon as the output register is free. A seed runs
	// ST_MUL/ST_ADD four times: the multiply is registered in ST_MUL, and
	// ST_ADD adds the round number and writes one state word.
	typedef enum logic [1:0] {ST_IDLE, ST_WORK, ST_MUL, ST_ADD} state_t;

	state_t            st_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [1:0]        idx_q;
	logic [WORD_W-1:0] w_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] words_q [4];
	logic              out_valid_q;
	logic [OUT_W-1:0]  result_q;

	logic              out_free;
	logic              done_now;
	logic              accept;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] w_add;
	logic [WORD_W-1:0] new_w3;

	// The output register frees up in the same cycle its result is taken,
	// so a finished transaction can leave while the next one enters.
	assign out_free = !out_valid_q || !out_stall;
	assign done_now = out_free && ((st_q == ST_WORK) || ((st_q == ST_ADD) && (idx_q == 2'd3)));
	assign in_stall = (st_q != ST_IDLE) && !done_now;
	assign accept   = in_valid && !in_stall;

	// Shared seeding datapath: one 32x32 multiply (low half kept), registered,
	// then the add of the round number in the following cycle.
	assign mix    = w_q ^ (w_q >> 30);
	assign prod   = SEED_MULT * mix;
	assign w_add  = prod_q + {30'd0, idx_q} + 32'd1;
	assign new_w3 = xs_next(words_q[0], words_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cmd_q       <= CMD_SEED;
			idx_q       <= 2'd0;
			w_q         <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			for (int k = 0; k < 4; k++) begin
				words_q[k] <= '0;
			end
		end else begin
			// A finishing transaction loads the output register; otherwise a
			// taken result empties it.
			if (done_now) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Work on the held transaction.
			unique case (st_q)
				ST_IDLE: begin
				end
				ST_WORK: begin
					if (out_free) begin
						unique case (cmd_q)
							CMD_DRAW15: begin
								result_q   <= {16'd0, new_w3[30:16]};
								words_q[0] <= words_q[1];
								words_q[1] <= words_q[2];
								words_q[2] <= words_q[3];
								words_q[3] <= new_w3;
							end
							CMD_FRAC31: begin
								result_q   <= new_w3[30:0];
								words_q[0] <= words_q[1];
								words_q[1] <= words_q[2];
								words_q[2] <= words_q[3];
								words_q[3] <= new_w3;
							end
							default: begin
								// Unused code: zero result, state untouched.
								result_q <= '0;
							end
						endcase
					end
				end
				ST_MUL: begin
					prod_q <= prod;
					st_q   <= ST_ADD;
				end
				ST_ADD: begin
					if (idx_q != 2'd3) begin
						w_q            <= w_add;
						words_q[idx_q] <= w_add;
						idx_q          <= idx_q + 2'd1;
						st_q           <= ST_MUL;
					end else if (out_free) begin
						words_q[idx_q] <= w_add;
						result_q       <= '0;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			// Take a new transaction, or return to idle once the held one
			// finishes with nothing new arriving.
			if (accept) begin
				cmd_q <= cmd;
				idx_q <= 2'd0;
				if (cmd == CMD_SEED) begin
					w_q  <= seed_value + SEED_OFFSET;
					st_q <= ST_MUL;
				end else begin
					st_q <= ST_WORK;
				end
			end else if (done_now) begin
				idx_q <= 2'd0;
				st_q  <= ST_IDLE;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = result_q;

	// A seed round is only ever in progress for a seed transaction.
	`XS_ASSERT_CLK(a_seed_cmd, (st_q == ST_MUL || st_q == ST_ADD) |-> (cmd_q == CMD_SEED), "seed sequencer running for a non-seed command")
	// The registered product is always followed by its add.
	`XS_ASSERT_CLK(a_mul_then_add, (st_q == ST_MUL) |=> (st_q == ST_ADD), "multiply not followed by add")
	// A finished seed delivers a zero result.
	`XS_ASSERT_CLK(a_seed_zero, (done_now && cmd_q == CMD_SEED) |=> (out_valid && random_value == '0), "seed result not zero")
	// A 15-bit draw leaves the upper result bits clear.
	`XS_ASSERT_CLK(a_draw15_range, (done_now && cmd_q == CMD_DRAW15) |=> (random_value[30:15] == 16'd0), "15-bit draw out of range")
	// No transaction is taken while one is held and not finishing.
	`XS_ASSERT_ALWAYS(a_no_overrun, (st_q != ST_IDLE && !done_now) |-> in_stall, "accepted while busy")

endmodule

// ===== dv/xorshift128_prng_with_seed_tb.sv =====
// ----------------------------------------------------------------------------
// xorshift128_prng_with_seed_tb
// Self-checking bench for the seeded xorshift128 generator. A queue of seed,
// draw, fraction and unused commands feeds a bursty sender. A shadow copy of the four
// state words predicts every result. A monitor behind a randomly stalling
// receiver checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module xorshift128_prng_with_seed_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import xs128_pkg::*;

	// Command 3 has no name in the package. The block must answer it with a
	// zero and leave its state alone.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// The bench keeps its own copy of the seeding constants so that the
	// prediction does not lean on the package.
	localparam logic [WORD_W-1:0] SEED_CHAIN_MULT = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_BIAS       = 32'd100;

	localparam int RANDOM_ITEMS  = 1750;
	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] seed;
		logic              hold;	// Wait until all results are back before sending.
	} prng_request_t;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_PERIODIC
	} sink_mode_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd          = '0;
	logic [WORD_W-1:0]   seed_value   = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [OUT_W-1:0]    random_value;

	prng_request_t       request_q[$];
	logic [OUT_W-1:0]    expected_values_q[$];
	logic [WORD_W-1:0]   shadow_words[4] = '{default: '0};

	int                  mismatch_count = 0;
	int                  burst_left     = 0;
	int                  gap_left       = 0;
	int                  stall_left     = 0;
	int                  stall_phase    = 0;
	sink_mode_t          stall_mode     = SINK_FREE;

	xorshift128_prng_with_seed dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value)
	);

	always #10 clk = ~clk;

	// Applies one command to the shadow state and returns the value that the
	// block must produce for it.
	function automatic logic [OUT_W-1:0] predict_random_value(input logic [CMD_W-1:0] op,
	                                                          input logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] t;
		logic [OUT_W-1:0]  value;
		value = '0;
		case (op)
			CMD_SEED: begin
				// The chain runs from seed + 100, and each link feeds the next word.
				w = seed + SEED_BIAS;
				for (int k = 1; k <= 4; k++) begin
					w = SEED_CHAIN_MULT * (w ^ (w >> 30)) + WORD_W'(k);
					shadow_words[k-1] = w;
				end
			end
			CMD_DRAW15, CMD_FRAC31: begin
				t = shadow_words[0] ^ (shadow_words[0] << 11);
				w = shadow_words[3];
				shadow_words[0] = shadow_words[1];
				shadow_words[1] = shadow_words[2];
				shadow_words[2] = w;
				w = (w ^ (w >> 19)) ^ (t ^ (t >> 8));
				shadow_words[3] = w;
				if (op == CMD_DRAW15)
					value = {16'd0, w[30:16]};
				else
					value = w[30:0];
			end
			default: value = '0;
		endcase
		return value;
	endfunction

	task automatic add_request(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] seed,
	                           input logic hold = 1'b0);
		prng_request_t req;
		req.op   = op;
		req.seed = seed;
		req.hold = hold;
		request_q.push_back(req);
	endtask

	task automatic note_failure(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// The sender. A transaction completes at an edge where valid is high and
	// stall is low; its prediction is made at that same edge from the values
	// that were on the pins. A new command goes out only when the previous one
	// has been taken, so a stalled payload never changes. Traffic comes in
	// bursts of random length separated by random gaps, and a request marked
	// hold waits until every outstanding result, including one taken at this
	// very edge, has come back.
	always @(posedge clk) begin : sender
		prng_request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_values_q.push_back(predict_random_value(cmd, seed_value));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() == 0 ||
				             (request_q[0].hold && expected_values_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					req = request_q.pop_front();
					in_valid   <= 1'b1;
					cmd        <= req.op;
					seed_value <= req.seed;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// About a quarter of the bursts run straight into the next one.
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// The receiver switches at random between stall patterns:
	// no stall at all, light random stall, heavy random stall, and a fixed
	// two-out-of-three pattern.
	always @(posedge clk) begin : receiver
		if (stall_left == 0) begin
			stall_mode = sink_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			SINK_FREE:  out_stall <= 1'b0;
			SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			SINK_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default:    out_stall <= (stall_phase % 3 != 0);
		endcase
	end

	// The monitor. Every transaction on the result side is matched against the
	// oldest prediction.
	always @(posedge clk) begin : monitor
		logic [OUT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_values_q.size() == 0) begin
				note_failure($sformatf("unexpected result random_value=%h", random_value));
			end else begin
				want = expected_values_q.pop_front();
				if (random_value !== want)
					note_failure($sformatf("random_value mismatch: expected %h, got %h",
					                       want, random_value));
			end
		end
	end

	// Stimulus and end of test.
	initial begin : stimulus
		int               issued;
		int               pick;
		logic [CMD_W-1:0] op;
		logic [WORD_W-1:0] seed;

		// Before any seed the state is all zero, so every draw must return zero.
		add_request(CMD_DRAW15, 32'hFFFF_FFFF);
		add_request(CMD_FRAC31, 32'h0000_0000);
		add_request(CMD_UNUSED, 32'hA5A5_5A5A);
		add_request(CMD_FRAC31, 32'h5A5A_A5A5);
		// The smallest seed, then a draw of each kind.
		add_request(CMD_SEED, 32'h0000_0000);
		add_request(CMD_DRAW15, 32'hFFFF_FFFF);
		add_request(CMD_FRAC31, 32'h0000_0000);
		// The largest seed wraps when the bias is added.
		add_request(CMD_SEED, 32'hFFFF_FFFF);
		add_request(CMD_FRAC31, 32'hFFFF_FFFF);
		add_request(CMD_DRAW15, 32'h0000_0000);
		// A seed that lands exactly on zero once the bias is added.
		add_request(CMD_SEED, 32'hFFFF_FF9C);
		add_request(CMD_DRAW15, 32'h1234_5678);
		// The unused command between draws must leave the state untouched.
		add_request(CMD_UNUSED, 32'hFFFF_FFFF);
		add_request(CMD_FRAC31, 32'h8765_4321);
		// Back-to-back seeds, with the sender waiting for an empty pipe first.
		add_request(CMD_SEED, 32'h8000_0000, 1'b1);
		add_request(CMD_SEED, 32'h7FFF_FFFF);
		add_request(CMD_DRAW15, 32'hDEAD_BEEF);
		add_request(CMD_DRAW15, 32'h0000_0001);
		add_request(CMD_FRAC31, 32'hFFFF_FFFE);
		add_request(CMD_FRAC31, 32'h0F0F_0F0F);

		// Random part: long runs of draws on random seeds, with an occasional
		// reseed, an occasional unused command, and a few forced drains.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			seed = $urandom;
			if (pick < 4) begin
				op = CMD_SEED;
				case ($urandom_range(0, 5))
					0:       seed = 32'h0000_0000;
					1:       seed = 32'hFFFF_FFFF;
					2:       seed = 32'hFFFF_FF9C + $urandom_range(0, 199);
					default: seed = $urandom;
				endcase
			end else if (pick < 7) begin
				op = CMD_UNUSED;
			end else if (pick < 53) begin
				op = CMD_DRAW15;
			end else begin
				op = CMD_FRAC31;
			end
			add_request(op, seed, (issued % 450 == 200));
			if (op != CMD_UNUSED)
				issued++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_values_q.size() != 0)
			@(posedge clk);
		// A seed keeps the block busy through its multiply/add rounds; give any stray
		// result time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_values_q.size() == 0)
			$display("xorshift128_prng_with_seed_tb OK");
		else
			$display("xorshift128_prng_with_seed_tb NOT OK");
		$finish;
	end

	// A run that hangs is stopped here and reported as NOT OK.
	initial begin : watchdog
		#10_000_000;
		$display("xorshift128_prng_with_seed_tb NOT OK");
		$finish;
	end

endmodule
